// ===== design/bnk_pkg.sv =====
// ----------------------------------------------------------------------------
// bnk_pkg
// Types, codes and step functions shared by the Brownian node kick pipeline.
// ----------------------------------------------------------------------------
package bnk_pkg;

	// register stages from input register to output register
	localparam int NSTAGE    = 146;
	localparam int SQ_STEPS  = 33;
	localparam int DIV_STEPS = 32;

	localparam logic [2:0] MODE_FREE3D = 3'd0;
	localparam logic [2:0] MODE_PLANAR = 3'd1;
	localparam logic [2:0] MODE_AXIAL  = 3'd2;
	localparam logic [2:0] MODE_PROJ   = 3'd3;
	localparam logic [2:0] MODE_TRUNC  = 3'd4;
	localparam logic [2:0] MODE_ROTZ   = 3'd5;

	localparam logic [1:0] CFG_MODE       = 2'd0;
	localparam logic [1:0] CFG_KICK_SCALE = 2'd1;
	localparam logic [1:0] CFG_CUTOFF     = 2'd2;
	localparam logic [1:0] CFG_DIFFUSION  = 2'd3;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] noise_x;
		logic signed [15:0] noise_y;
		logic signed [15:0] noise_z;
	} node_t;

	typedef struct packed {
		logic signed [31:0] kick_x;
		logic signed [31:0] kick_y;
		logic signed [31:0] kick_z;
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic signed [63:0] energy_term;
		logic               degenerate;
	} kick_t;

	// one square root step: remainder, partial root, unconsumed radicand
	typedef struct packed {
		logic [35:0] rem;
		logic [32:0] root;
		logic [65:0] rad;
	} sq_t;

	// one restoring division step: remainder, dividend/quotient shifter, divisor
	typedef struct packed {
		logic [32:0] rem;
		logic [31:0] lo;
		logic [32:0] dvs;
	} dv_t;

	// per item side data riding along the long arithmetic segments
	typedef struct packed {
		logic [2:0]       mode;
		logic             deg;
		logic             trunc;
		logic [2:0][31:0] p;
		logic [2:0][31:0] k0;
		logic [2:0][32:0] t;
		logic [2:0][31:0] kp;
	} sb_t;

	function automatic sq_t sq_step(input sq_t a);
		logic [35:0] r2;
		logic [35:0] tr;
		sq_t o;
		r2 = {a.rem[33:0], a.rad[65:64]};
		tr = {1'b0, a.root, 2'b01};
		if (r2 >= tr) begin
			o.rem  = r2 - tr;
			o.root = {a.root[31:0], 1'b1};
		end else begin
			o.rem  = r2;
			o.root = {a.root[31:0], 1'b0};
		end
		o.rad = {a.rad[63:0], 2'b00};
		return o;
	endfunction

	function automatic dv_t dv_step(input dv_t a);
		logic [33:0] r2;
		logic [33:0] d;
		dv_t o;
		r2    = {a.rem, a.lo[31]};
		d     = {1'b0, a.dvs};
		o.dvs = a.dvs;
		if (r2 >= d) begin
			o.rem = 33'(r2 - d);
			o.lo  = {a.lo[30:0], 1'b1};
		end else begin
			o.rem = r2[32:0];
			o.lo  = {a.lo[30:0], 1'b0};
		end
		return o;
	endfunction

	// sign and magnitude to saturated signed 32
	function automatic logic [31:0] sat_sm(input logic neg, input logic [63:0] m);
		logic [31:0] r;
		if (!neg) begin
			r = (m > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
		end else begin
			r = (m > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
		end
		return r;
	endfunction

	function automatic logic [31:0] sat_s(input logic signed [35:0] v);
		logic [31:0] r;
		if (v > $signed(36'h0_7FFF_FFFF)) begin
			r = 32'h7FFF_FFFF;
		end else if (v < $signed(36'hF_8000_0000)) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== design/bnk_isqrt.sv =====
// ----------------------------------------------------------------------------
// bnk_isqrt
// Pipelined floor square root, 66-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module bnk_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [65:0] rad,
	output logic [32:0] root
);

	bnk_pkg::sq_t st_s [0:bnk_pkg::SQ_STEPS-1];
	bnk_pkg::sq_t init;

	always_comb begin
		init.rem  = '0;
		init.root = '0;
		init.rad  = rad;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= bnk_pkg::sq_step(init);
			for (int j = 1; j < bnk_pkg::SQ_STEPS; j++) begin
				st_s[j] <= bnk_pkg::sq_step(st_s[j-1]);
			end
		end
	end

	assign root = st_s[bnk_pkg::SQ_STEPS-1].root;

endmodule

// ===== design/bnk_div.sv =====
// ----------------------------------------------------------------------------
// bnk_div
// Pipelined restoring divider, 64 by 33 bits, 32-bit quotient, bit per stage.
// Caller guarantees the quotient fits 32 bits.
// ----------------------------------------------------------------------------
module bnk_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] dvd,
	input  logic [32:0] divisor,
	output logic [31:0] quo
);

	bnk_pkg::dv_t st_s [0:bnk_pkg::DIV_STEPS-1];
	bnk_pkg::dv_t init;

	always_comb begin
		init.rem = {1'b0, dvd[63:32]};
		init.lo  = dvd[31:0];
		init.dvs = divisor;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= bnk_pkg::dv_step(init);
			for (int j = 1; j < bnk_pkg::DIV_STEPS; j++) begin
				st_s[j] <= bnk_pkg::dv_step(st_s[j-1]);
			end
		end
	end

	assign quo = st_s[bnk_pkg::DIV_STEPS-1].lo;

endmodule

// ===== design/brownian_node_kick.sv =====
// ----------------------------------------------------------------------------
// brownian_node_kick: pipelined from accepted word to result word.
// Throughput one word per cycle when not stalled; the latency is set mostly
// by the two bit-per-stage sqrt segments and the two bit-per-stage divide
// segments. A result word nobody takes holds the whole pipe, input included.
// Reset clears valid bits and loads mode 0, kick_scale/cutoff/diffusion 1.0.
// ----------------------------------------------------------------------------
module brownian_node_kick (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  bnk_pkg::node_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output bnk_pkg::kick_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_data
);

	// ---------------------------------------------------------------- config
	logic [2:0]  mode_q;
	logic [31:0] kick_scale_q;
	logic [31:0] cutoff_q;
	logic [31:0] diffusion_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= bnk_pkg::MODE_FREE3D;
			kick_scale_q <= bnk_pkg::ONE_Q16;
			cutoff_q     <= bnk_pkg::ONE_Q16;
			diffusion_q  <= bnk_pkg::ONE_Q16;
		end else if (cfg_valid) begin
			case (cfg_index)
				bnk_pkg::CFG_MODE:       mode_q       <= cfg_data[2:0];
				bnk_pkg::CFG_KICK_SCALE: kick_scale_q <= cfg_data;
				bnk_pkg::CFG_CUTOFF:     cutoff_q     <= cfg_data;
				bnk_pkg::CFG_DIFFUSION:  diffusion_q  <= cfg_data;
				default:                 mode_q       <= mode_q;
			endcase
		end
	end

	// -------------------------------------------------------- flow control
	// Whole pipe advances together; it holds only when the output register
	// has a word nobody took. Valid bits shift alongside the data.
	logic                       adv;
	logic [bnk_pkg::NSTAGE-1:0] stage_vld_q;

	assign adv       = !stage_vld_q[bnk_pkg::NSTAGE-1] || rsp_ready;
	assign req_ready = adv;
	assign rsp_valid = stage_vld_q[bnk_pkg::NSTAGE-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else if (adv) begin
			stage_vld_q <= {stage_vld_q[bnk_pkg::NSTAGE-2:0], req_valid};
		end
	end

	// ---------------------------------------------- s1: noise times scale
	logic [2:0][31:0] in_p;
	logic [2:0][15:0] in_n;
	logic [2:0][15:0] nmag;

	assign in_p = {req.pos_z, req.pos_y, req.pos_x};
	assign in_n = {req.noise_z, req.noise_y, req.noise_x};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nmag[i] = in_n[i][15] ? (~in_n[i] + 16'd1) : in_n[i];
		end
	end

	logic [2:0][47:0] prod_s1;
	logic [2:0]       nneg_s1;
	logic [2:0][31:0] p_s1;
	logic [2:0]       mode_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= {32'd0, nmag[i]} * {16'd0, kick_scale_q};
				nneg_s1[i] <= in_n[i][15];
			end
			p_s1    <= in_p;
			mode_s1 <= mode_q;
		end
	end

	// ------------------------------------- s2: round, saturate, mode shaping
	// Q4.12 * Q16.16 drops 12 bits, rounded half away from zero.
	// Rotation mode ignores noise: kick = (-x - y, x - y, 0).
	logic [2:0][31:0]   sc;
	logic signed [35:0] px36, py36, rx, ry;
	logic [2:0][31:0]   k0_n;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sc[i] = bnk_pkg::sat_sm(nneg_s1[i],
				{15'd0, ({1'b0, prod_s1[i]} + 49'd2048) >> 12});
		end
		px36 = {{4{p_s1[0][31]}}, p_s1[0]};
		py36 = {{4{p_s1[1][31]}}, p_s1[1]};
		rx   = 36'sd0 - px36 - py36;
		ry   = px36 - py36;
		case (mode_s1)
			bnk_pkg::MODE_FREE3D: k0_n = sc;
			bnk_pkg::MODE_PROJ:   k0_n = sc;
			bnk_pkg::MODE_TRUNC:  k0_n = sc;
			bnk_pkg::MODE_PLANAR: k0_n = {32'd0, sc[1], sc[0]};
			bnk_pkg::MODE_AXIAL:  k0_n = {64'd0, sc[0]};
			bnk_pkg::MODE_ROTZ:   k0_n = {32'd0, bnk_pkg::sat_s(ry), bnk_pkg::sat_s(rx)};
			default:              k0_n = '0;
		endcase
	end

	logic [2:0][31:0] k0_s2;
	logic [2:0][31:0] p_s2;
	logic [2:0]       mode_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			k0_s2   <= k0_n;
			p_s2    <= p_s1;
			mode_s2 <= mode_s1;
		end
	end

	// ------------------------------------ s3: projected target t = p + kick
	bnk_pkg::sb_t sb3_n;

	always_comb begin
		sb3_n.mode  = mode_s2;
		sb3_n.trunc = 1'b0;
		sb3_n.p     = p_s2;
		sb3_n.k0    = k0_s2;
		sb3_n.kp    = '0;
		for (int i = 0; i < 3; i++) begin
			sb3_n.t[i] = {p_s2[i][31], p_s2[i]} + {k0_s2[i][31], k0_s2[i]};
		end
		// zero target has no direction: in the projection modes flag it and force a zero kick
		sb3_n.deg = (sb3_n.t == '0) &&
			(mode_s2 == bnk_pkg::MODE_PROJ || mode_s2 == bnk_pkg::MODE_TRUNC);
	end

	bnk_pkg::sb_t sb_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s3 <= sb3_n;
		end
	end

	// --------------------------------------------------- s4: squares
	logic [2:0][31:0] pm4;
	logic [2:0][32:0] tm4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pm4[i] = sb_s3.p[i][31] ? (~sb_s3.p[i] + 32'd1) : sb_s3.p[i];
			tm4[i] = sb_s3.t[i][32] ? (~sb_s3.t[i] + 33'd1) : sb_s3.t[i];
		end
	end

	logic [2:0][63:0] sqp_s4;
	logic [2:0][65:0] sqt_s4;
	bnk_pkg::sb_t     sb_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sqp_s4[i] <= {32'd0, pm4[i]} * {32'd0, pm4[i]};
				sqt_s4[i] <= {33'd0, tm4[i]} * {33'd0, tm4[i]};
			end
			sb_s4 <= sb_s3;
		end
	end

	// ------------------------------------------------ s5: sums of squares
	logic [65:0]  radp_s5;
	logic [65:0]  radt_s5;
	bnk_pkg::sb_t sb_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			radp_s5 <= {2'b00, sqp_s4[0]} + {2'b00, sqp_s4[1]} + {2'b00, sqp_s4[2]};
			radt_s5 <= sqt_s4[0] + sqt_s4[1] + sqt_s4[2];
			sb_s5   <= sb_s4;
		end
	end

	// ------------------------------------- |p| and |t| square root chains
	logic [32:0] root_p;
	logic [32:0] root_t;

	bnk_isqrt u_sqrt_p (.clk(clk), .en(adv), .rad(radp_s5), .root(root_p));
	bnk_isqrt u_sqrt_t (.clk(clk), .en(adv), .rad(radt_s5), .root(root_t));

	bnk_pkg::sb_t sb_sqa_s [0:bnk_pkg::SQ_STEPS-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_sqa_s[0] <= sb_s5;
			for (int j = 1; j < bnk_pkg::SQ_STEPS; j++) begin
				sb_sqa_s[j] <= sb_sqa_s[j-1];
			end
		end
	end

	// -------------------------------------- s6: |t_i| * |p| for the rescale
	bnk_pkg::sb_t     sbA;
	logic [2:0][32:0] tm6;

	assign sbA = sb_sqa_s[bnk_pkg::SQ_STEPS-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tm6[i] = sbA.t[i][32] ? (~sbA.t[i] + 33'd1) : sbA.t[i];
		end
	end

	logic [2:0][63:0] dvd_s6;
	logic [32:0]      dvs_s6;
	bnk_pkg::sb_t     sb_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dvd_s6[i] <= {31'd0, tm6[i]} * {32'd0, root_p[31:0]};
			end
			dvs_s6 <= root_t;
			sb_s6  <= sbA;
		end
	end

	// -------------------------------------- divide by |t| (quotient <= |p|)
	logic [2:0][31:0] quo_a;

	for (genvar g = 0; g < 3; g++) begin : g_div_a
		bnk_div u_div (
			.clk(clk), .en(adv), .dvd(dvd_s6[g]), .divisor(dvs_s6), .quo(quo_a[g])
		);
	end

	bnk_pkg::sb_t sb_dva_s [0:bnk_pkg::DIV_STEPS-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_dva_s[0] <= sb_s6;
			for (int j = 1; j < bnk_pkg::DIV_STEPS; j++) begin
				sb_dva_s[j] <= sb_dva_s[j-1];
			end
		end
	end

	// ---------------------------- s7: projected kick = rescaled t minus p
	bnk_pkg::sb_t       sbB;
	bnk_pkg::sb_t       sb7_n;
	logic signed [35:0] qx, pv;

	assign sbB = sb_dva_s[bnk_pkg::DIV_STEPS-1];

	always_comb begin
		sb7_n = sbB;
		qx    = '0;
		pv    = '0;
		for (int i = 0; i < 3; i++) begin
			qx = {4'd0, quo_a[i]};
			pv = {{4{sbB.p[i][31]}}, sbB.p[i]};
			if (sbB.t[i][32]) begin
				qx = 36'sd0 - qx;
			end
			sb7_n.kp[i] = sbB.deg ? 32'd0 : bnk_pkg::sat_s(qx - pv);
		end
	end

	bnk_pkg::sb_t sb_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s7 <= sb7_n;
		end
	end

	// ---------------------------------------- s8, s9: |kick| squared sum
	logic [2:0][31:0] km8;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			km8[i] = sb_s7.kp[i][31] ? (~sb_s7.kp[i] + 32'd1) : sb_s7.kp[i];
		end
	end

	logic [2:0][63:0] sqk_s8;
	bnk_pkg::sb_t     sb_s8;
	logic [65:0]      radk_s9;
	bnk_pkg::sb_t     sb_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sqk_s8[i] <= {32'd0, km8[i]} * {32'd0, km8[i]};
			end
			sb_s8   <= sb_s7;
			radk_s9 <= {2'b00, sqk_s8[0]} + {2'b00, sqk_s8[1]} + {2'b00, sqk_s8[2]};
			sb_s9   <= sb_s8;
		end
	end

	logic [32:0] root_k;

	bnk_isqrt u_sqrt_k (.clk(clk), .en(adv), .rad(radk_s9), .root(root_k));

	bnk_pkg::sb_t sb_sqb_s [0:bnk_pkg::SQ_STEPS-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_sqb_s[0] <= sb_s9;
			for (int j = 1; j < bnk_pkg::SQ_STEPS; j++) begin
				sb_sqb_s[j] <= sb_sqb_s[j-1];
			end
		end
	end

	// --------------------------- s10: truncation test and |k_i| * cutoff
	bnk_pkg::sb_t     sbC;
	bnk_pkg::sb_t     sb10_n;
	logic [2:0][31:0] km10;

	assign sbC = sb_sqb_s[bnk_pkg::SQ_STEPS-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			km10[i] = sbC.kp[i][31] ? (~sbC.kp[i] + 32'd1) : sbC.kp[i];
		end
		sb10_n       = sbC;
		sb10_n.trunc = root_k > {1'b0, cutoff_q};
	end

	logic [2:0][63:0] dvd_s10;
	logic [32:0]      dvs_s10;
	bnk_pkg::sb_t     sb_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dvd_s10[i] <= {32'd0, km10[i]} * {32'd0, cutoff_q};
			end
			dvs_s10 <= root_k;
			sb_s10  <= sb10_n;
		end
	end

	logic [2:0][31:0] quo_b;

	for (genvar g = 0; g < 3; g++) begin : g_div_b
		bnk_div u_div (
			.clk(clk), .en(adv), .dvd(dvd_s10[g]), .divisor(dvs_s10), .quo(quo_b[g])
		);
	end

	bnk_pkg::sb_t sb_dvb_s [0:bnk_pkg::DIV_STEPS-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_dvb_s[0] <= sb_s10;
			for (int j = 1; j < bnk_pkg::DIV_STEPS; j++) begin
				sb_dvb_s[j] <= sb_dvb_s[j-1];
			end
		end
	end

	// ------------------------------------------- s11: final kick per mode
	bnk_pkg::sb_t     sbD;
	logic [2:0][31:0] k_n;
	logic [2:0][31:0] kt;

	assign sbD = sb_dvb_s[bnk_pkg::DIV_STEPS-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			kt[i] = sbD.kp[i][31] ? (~quo_b[i] + 32'd1) : quo_b[i];
		end
		case (sbD.mode)
			bnk_pkg::MODE_PROJ:  k_n = sbD.kp;
			bnk_pkg::MODE_TRUNC: k_n = sbD.trunc ? kt : sbD.kp;
			default:             k_n = sbD.k0;
		endcase
	end

	logic [2:0][31:0] k_s11;
	logic [2:0][31:0] p_s11;
	logic             deg_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s11   <= k_n;
			p_s11   <= sbD.p;
			deg_s11 <= sbD.deg;
		end
	end

	// ------------------------- s12: diffusion * |k_i| and k_i * p_i terms
	logic [2:0][31:0]   km12;
	logic signed [63:0] dot_n [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			km12[i]  = k_s11[i][31] ? (~k_s11[i] + 32'd1) : k_s11[i];
			dot_n[i] = $signed(k_s11[i]) * $signed(p_s11[i]);
		end
	end

	logic [2:0][63:0] fprod_s12;
	logic [2:0][63:0] dot_s12;
	logic [2:0][31:0] k_s12;
	logic             deg_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				fprod_s12[i] <= {32'd0, km12[i]} * {32'd0, diffusion_q};
				dot_s12[i]   <= dot_n[i];
			end
			k_s12   <= k_s11;
			deg_s12 <= deg_s11;
		end
	end

	// ------------------------------- s13: force rounding, exact dot sum
	// force = -(D * k) >> 16 rounded half away from zero
	logic [65:0] dsum;
	logic [65:0] dabs;

	always_comb begin
		dsum = {{2{dot_s12[0][63]}}, dot_s12[0]} + {{2{dot_s12[1][63]}}, dot_s12[1]}
			+ {{2{dot_s12[2][63]}}, dot_s12[2]};
		dabs = dsum[65] ? (~dsum + 66'd1) : dsum;
	end

	logic [2:0][31:0] force_s13;
	logic [2:0][31:0] k_s13;
	logic [63:0]      dm_s13;
	logic             dneg_s13;
	logic             deg_s13;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				force_s13[i] <= bnk_pkg::sat_sm(!k_s12[i][31],
					(fprod_s12[i] + 64'h8000) >> 16);
			end
			k_s13    <= k_s12;
			dm_s13   <= dabs[63:0];
			dneg_s13 <= dsum[65];
			deg_s13  <= deg_s12;
		end
	end

	// ----------------------- s14, s15: |dot| * diffusion in two 32x32 halves
	logic [63:0]      pl_s14;
	logic [63:0]      ph_s14;
	logic [2:0][31:0] force_s14;
	logic [2:0][31:0] k_s14;
	logic             dneg_s14;
	logic             deg_s14;
	logic [95:0]      e_s15;
	logic [2:0][31:0] force_s15;
	logic [2:0][31:0] k_s15;
	logic             dneg_s15;
	logic             deg_s15;

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s14    <= {32'd0, dm_s13[31:0]} * {32'd0, diffusion_q};
			ph_s14    <= {32'd0, dm_s13[63:32]} * {32'd0, diffusion_q};
			force_s14 <= force_s13;
			k_s14     <= k_s13;
			dneg_s14  <= dneg_s13;
			deg_s14   <= deg_s13;
			e_s15     <= {32'd0, pl_s14} + {ph_s14, 32'd0} + 96'h8000;
			force_s15 <= force_s14;
			k_s15     <= k_s14;
			dneg_s15  <= dneg_s14;
			deg_s15   <= deg_s14;
		end
	end

	// ------------------------------- s16: energy saturation, output word
	// energy sign is opposite the dot product; it saturates to signed 64 bits
	logic        eneg;
	logic [63:0] er;
	logic [63:0] energy_n;

	always_comb begin
		eneg = !dneg_s15;
		er   = e_s15[79:16];
		if (e_s15[95:80] != 16'd0) begin
			energy_n = eneg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end else if (!eneg) begin
			energy_n = (er > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : er;
		end else begin
			energy_n = (er > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000
				: (~er + 64'd1);
		end
	end

	bnk_pkg::kick_t rsp_s16;

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s16.kick_x      <= k_s15[0];
			rsp_s16.kick_y      <= k_s15[1];
			rsp_s16.kick_z      <= k_s15[2];
			rsp_s16.force_x     <= force_s15[0];
			rsp_s16.force_y     <= force_s15[1];
			rsp_s16.force_z     <= force_s15[2];
			rsp_s16.energy_term <= energy_n;
			rsp_s16.degenerate  <= deg_s15;
		end
	end

	assign rsp = rsp_s16;

	// ------------------------------------------------------------ checks
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.degenerate |->
			(mode_q == bnk_pkg::MODE_PROJ || mode_q == bnk_pkg::MODE_TRUNC))
		else $error("degenerate flag outside projection modes");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.degenerate |->
			rsp.kick_x == 32'sd0 && rsp.kick_y == 32'sd0 && rsp.kick_z == 32'sd0)
		else $error("degenerate word carries a nonzero kick");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (mode_q == bnk_pkg::MODE_PLANAR || mode_q == bnk_pkg::MODE_AXIAL
			|| mode_q == bnk_pkg::MODE_ROTZ) |-> rsp.kick_z == 32'sd0)
		else $error("z kick not cleared in a planar mode");

	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(stage_vld_q))
		else $error("pipeline moved while stalled");

endmodule
